FILE: hdl/gpc_pkg.sv
// Shared constants, types and the pattern function of the gradient pattern coder.
package gpc_pkg;

    // Longest row the line store holds.
    localparam int MAX_WIDTH = 256;
    // Bits of a column index into the line store.
    localparam int COL_W = $clog2(MAX_WIDTH);
    // Bits of an active row width (1..MAX_WIDTH).
    localparam int ACT_W = COL_W + 1;
    // Bits of the image_width register.
    localparam int CFG_W = 9;
    // Width used when the register value is compared against MAX_WIDTH.
    localparam int CMP_W = (CFG_W > ACT_W) ? CFG_W : ACT_W;
    // Reset value of image_width.
    localparam logic [CFG_W-1:0] WIDTH_RESET = CFG_W'(256);

    // Pixel and code widths.
    localparam int PIX_W  = 8;
    localparam int CODE_W = 6;

    // Configuration port.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    // Register index taken from the byte address.
    localparam logic REG_IMAGE_WIDTH = 1'b0;

    // Result queue.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    // Pixel word held between the column stage and the coding stage.
    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             last;
        logic             col_zero;
        logic             first_row;
        logic             held_valid;
    } t_stage_item;

    // Line store access issued by the column stage.
    typedef struct packed {
        logic             en;
        logic [COL_W-1:0] addr;
        logic [PIX_W-1:0] data;
    } t_mem_req;

    // One result word.
    typedef struct packed {
        logic [CODE_W-1:0] pattern_code;
        logic              code_row_end;
        logic              last_of_step;
    } t_result;

    // Results pushed into the queue in one cycle, in order.
    typedef struct packed {
        logic [1:0] num;
        t_result    first;
        t_result    second;
    } t_push;

    // With d = P - neighbor, d_i > d_j holds exactly when neighbor_j > neighbor_i,
    // so the center pixel drops out of the comparisons.
    function automatic logic [CODE_W-1:0] pattern_of(
        input logic [PIX_W-1:0] right,
        input logic [PIX_W-1:0] up_right,
        input logic [PIX_W-1:0] upper,
        input logic [PIX_W-1:0] up_left
    );
        logic [CODE_W-1:0] code;
        code[5] = up_right > right;
        code[4] = upper > right;
        code[3] = up_left > right;
        code[2] = upper > up_right;
        code[1] = up_left > up_right;
        code[0] = up_left > upper;
        return code;
    endfunction

endpackage

FILE: hdl/gpc_if.sv
// Stream interfaces for pixel words in and pattern code words out.
interface gpc_pix_if;
    import gpc_pkg::*;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_value;
    logic             row_end;
    logic             frame_start;

    modport source (output valid, pixel_value, row_end, frame_start, input ready);
    modport sink (input valid, pixel_value, row_end, frame_start, output ready);
endinterface

interface gpc_code_if;
    import gpc_pkg::*;
    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] pattern_code;
    logic              code_row_end;
    logic              last_of_step;

    modport source (output valid, pattern_code, code_row_end, last_of_step, input ready);
    modport sink (input valid, pattern_code, code_row_end, last_of_step, output ready);
endinterface

FILE: hdl/gpc_ram.sv
// Generic simple dual-port RAM with registered read; a read of the address being
// written returns the old contents.
module gpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hdl/gpc_cfg.sv
// APB register block holding image_width.
module gpc_cfg import gpc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [CFG_W-1:0]      o_image_width
);

    logic [CFG_W-1:0] r_image_width;
    logic             wr_hit;

    // A write lands in the access phase; the two low address bits are not decoded.
    assign wr_hit = psel && penable && pwrite && (paddr[APB_ADDR_W-1] == REG_IMAGE_WIDTH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width <= WIDTH_RESET;
        end else if (wr_hit) begin
            r_image_width <= pwdata[CFG_W-1:0];
        end
    end

    // Read data for the addressed register; addresses beyond it read zero.
    always_comb begin
        prdata = '0;
        if (paddr[APB_ADDR_W-1] == REG_IMAGE_WIDTH) begin
            prdata = APB_DATA_W'(r_image_width);
        end
    end

    assign pready        = 1'b1;
    assign o_image_width = r_image_width;

endmodule

FILE: hdl/gpc_col_ctrl.sv
// Column stage: tracks the raster position, issues the line store access and
// registers the pixel word for the coding stage.
module gpc_col_ctrl import gpc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    gpc_pix_if.sink          i_pix,
    input  logic [CFG_W-1:0] i_image_width,
    input  logic             i_take,
    output logic             o_stage_valid,
    output t_stage_item      o_stage_item,
    output t_mem_req         o_mem_req
);

    logic [COL_W-1:0] r_col;
    logic             r_first_row;
    logic             r_held_valid;
    logic             r_stage_valid;
    t_stage_item      r_stage_item;

    logic [CMP_W-1:0] width_ext;
    logic [ACT_W-1:0] act_width;
    logic [ACT_W-1:0] col_ext;
    logic [ACT_W-1:0] col_sat;
    logic [COL_W-1:0] col;
    logic             last;
    logic             first_row;
    logic             held_valid;
    logic             accept;

    // Clamp the programmed width into 1..MAX_WIDTH.
    always_comb begin
        width_ext = CMP_W'(i_image_width);
        if (width_ext == '0) begin
            act_width = ACT_W'(1);
        end else if (width_ext > CMP_W'(MAX_WIDTH)) begin
            act_width = ACT_W'(MAX_WIDTH);
        end else begin
            act_width = width_ext[ACT_W-1:0];
        end
    end

    // Column of this word; a frame start restarts the row and drops a held pixel.
    always_comb begin
        col_ext    = i_pix.frame_start ? '0 : ACT_W'(r_col);
        col_sat    = (col_ext >= act_width) ? (act_width - ACT_W'(1)) : col_ext;
        col        = col_sat[COL_W-1:0];
        last       = i_pix.row_end || (col_sat == (act_width - ACT_W'(1)));
        first_row  = i_pix.frame_start || r_first_row;
        held_valid = !i_pix.frame_start && r_held_valid;
    end

    assign i_pix.ready = !r_stage_valid || i_take;
    assign accept      = i_pix.valid && i_pix.ready;

    // Read the upper neighbor and store this pixel at the same column.
    assign o_mem_req.en   = accept;
    assign o_mem_req.addr = col;
    assign o_mem_req.data = i_pix.pixel_value;

    // Raster position and stage valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col         <= '0;
            r_first_row   <= 1'b1;
            r_held_valid  <= 1'b0;
            r_stage_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_stage_valid <= 1'b1;
                if (last) begin
                    r_col        <= '0;
                    r_first_row  <= 1'b0;
                    r_held_valid <= 1'b0;
                end else begin
                    r_col        <= col + COL_W'(1);
                    r_first_row  <= first_row;
                    r_held_valid <= 1'b1;
                end
            end else if (i_take) begin
                r_stage_valid <= 1'b0;
            end
        end
    end

    // Pixel word for the coding stage.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_stage_item.pixel      <= i_pix.pixel_value;
            r_stage_item.last       <= last;
            r_stage_item.col_zero   <= (col == '0);
            r_stage_item.first_row  <= first_row;
            r_stage_item.held_valid <= held_valid;
        end
    end

    assign o_stage_valid = r_stage_valid;
    assign o_stage_item  = r_stage_item;

endmodule

FILE: hdl/gpc_coder.sv
// Coding stage: forms the pattern codes of the held pixel and of a row's last
// pixel, and keeps the upper neighbors of the held pixel.
module gpc_coder import gpc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_stage_valid,
    input  t_stage_item      i_stage_item,
    input  logic [PIX_W-1:0] i_upper,
    input  logic             i_room,
    output logic             o_take,
    output t_push            o_push
);

    logic [PIX_W-1:0] r_held_upper;
    logic [PIX_W-1:0] r_held_upper_left;

    logic [PIX_W-1:0] upper;
    logic [PIX_W-1:0] up_left;
    t_result          held_res;
    t_result          last_res;

    assign o_take = i_stage_valid && i_room;

    // Neighbors outside the frame read as zero.
    assign upper   = i_stage_item.first_row ? '0 : i_upper;
    assign up_left = (i_stage_item.col_zero || i_stage_item.first_row) ? '0 : r_held_upper;

    // The held pixel takes this pixel as its right neighbor.
    always_comb begin
        held_res.pattern_code = pattern_of(i_stage_item.pixel, upper, r_held_upper,
                                           r_held_upper_left);
        held_res.code_row_end = 1'b0;
        held_res.last_of_step = !i_stage_item.last;
        last_res.pattern_code = pattern_of('0, '0, upper, up_left);
        last_res.code_row_end = 1'b1;
        last_res.last_of_step = 1'b1;
    end

    // Results in order: held pixel first, then the row's last pixel.
    always_comb begin
        o_push.num    = 2'(i_stage_item.held_valid) + 2'(i_stage_item.last);
        o_push.first  = i_stage_item.held_valid ? held_res : last_res;
        o_push.second = last_res;
        if (!o_take) begin
            o_push.num = 2'd0;
        end
    end

    // A pixel that does not end its row becomes the held pixel.
    always_ff @(posedge i_clk) begin
        if (o_take && !i_stage_item.last) begin
            r_held_upper      <= upper;
            r_held_upper_left <= up_left;
        end
    end

endmodule

FILE: hdl/gpc_out_queue.sv
// Result queue: takes up to two words a cycle and hands out one per handshake.
module gpc_out_queue import gpc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_push      i_push,
    output logic       o_room,
    gpc_code_if.source o_code
);

    t_result           r_entry [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    logic              pop;
    logic [QPTR_W-1:0] wr_ptr_2nd;
    t_result           head;

    assign o_room     = r_count <= QCNT_W'(QUEUE_DEPTH - 2);
    assign pop        = o_code.valid && o_code.ready;
    assign wr_ptr_2nd = r_wr_ptr + QPTR_W'(1);

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push.num != 2'd0) begin
            r_entry[r_wr_ptr] <= i_push.first;
        end
        if (i_push.num == 2'd2) begin
            r_entry[wr_ptr_2nd] <= i_push.second;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + QPTR_W'(i_push.num);
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            r_count <= r_count + QCNT_W'(i_push.num) - QCNT_W'(pop);
        end
    end

    assign head                = r_entry[r_rd_ptr];
    assign o_code.valid        = r_count != '0;
    assign o_code.pattern_code = head.pattern_code;
    assign o_code.code_row_end = head.code_row_end;
    assign o_code.last_of_step = head.last_of_step;

endmodule

FILE: hdl/gradient_pattern_coder.sv
// Gradient pattern coder: grey pixel words in, 6-bit direction codes out.
// Throughput: one pixel word per cycle while the result queue has room, set by the
// line store's one read and one write. A word is registered in the column stage, then
// coded and written into the result queue when it has room; a row's last word adds its
// own code word behind the held pixel's. Reset (synchronous, active low) clears position,
// flags, queue and image_width (256); the line store is not cleared.
module gradient_pattern_coder import gpc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    gpc_pix_if.sink               i_pix,
    gpc_code_if.source            o_code,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [CFG_W-1:0] image_width;
    logic             stage_valid;
    t_stage_item      stage_item;
    t_mem_req         mem_req;
    logic [PIX_W-1:0] upper;
    logic             take;
    logic             room;
    t_push            push;

    // Configuration register.
    gpc_cfg u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_image_width (image_width)
    );

    // Column tracking and line store access.
    gpc_col_ctrl u_col_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_pix         (i_pix),
        .i_image_width (image_width),
        .i_take        (take),
        .o_stage_valid (stage_valid),
        .o_stage_item  (stage_item),
        .o_mem_req     (mem_req)
    );

    // Previous row store.
    gpc_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_wr_en   (mem_req.en),
        .i_wr_addr (mem_req.addr),
        .i_wr_data (mem_req.data),
        .i_rd_en   (mem_req.en),
        .i_rd_addr (mem_req.addr),
        .o_rd_data (upper)
    );

    // Pattern coding.
    gpc_coder u_coder (
        .i_clk         (i_clk),
        .i_stage_valid (stage_valid),
        .i_stage_item  (stage_item),
        .i_upper       (upper),
        .i_room        (room),
        .o_take        (take),
        .o_push        (push)
    );

    // Result queue toward the output channel.
    gpc_out_queue u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_code  (o_code)
    );

endmodule

FILE: bench/gpc_code_checker.sv
// Code checker: predicts the pattern code words for each accepted pixel word and compares them.
module gpc_code_checker import gpc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    gpc_pix_if                    i_pix,
    gpc_code_if                   i_code,
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic                  i_pready,
    input  logic [APB_ADDR_W-1:0] i_paddr,
    input  logic [APB_DATA_W-1:0] i_pwdata,
    output int                    o_mismatches,
    output int                    o_open_codes
);

    // Predictor state: line store, held window and row position.
    logic [PIX_W-1:0] line_mem [MAX_WIDTH];
    logic [PIX_W-1:0] held_pix;
    logic [PIX_W-1:0] held_ul;
    logic [PIX_W-1:0] held_up;
    int               next_col;
    bit               held_ok;
    bit               top_row;
    logic [CFG_W-1:0] width_reg;

    // Code words still to come, oldest first.
    t_result          code_q[$];
    int               fail_cnt = 0;

    assign o_mismatches = fail_cnt;

    // Six comparisons of the signed differences between the center and its neighbors.
    function automatic logic [CODE_W-1:0] direction_code(
        input logic [PIX_W-1:0] p,
        input logic [PIX_W-1:0] r,
        input logic [PIX_W-1:0] ur,
        input logic [PIX_W-1:0] u,
        input logic [PIX_W-1:0] ul
    );
        int d1, d2, d3, d4;
        d1 = int'(p) - int'(r);
        d2 = int'(p) - int'(ur);
        d3 = int'(p) - int'(u);
        d4 = int'(p) - int'(ul);
        return {d1 > d2, d1 > d3, d1 > d4, d2 > d3, d2 > d4, d3 > d4};
    endfunction

    function automatic t_result code_word(
        input logic [CODE_W-1:0] code,
        input logic              row_last,
        input logic              step_last
    );
        t_result w;
        w.pattern_code = code;
        w.code_row_end = row_last;
        w.last_of_step = step_last;
        return w;
    endfunction

    // Advance the predictor by one pixel word and queue the code words it causes.
    task automatic predict_codes(
        input logic [PIX_W-1:0] p,
        input logic             row_end,
        input logic             frame_start
    );
        int               w;
        int               c;
        bit               last;
        logic [PIX_W-1:0] up;
        logic [PIX_W-1:0] ul;
        if (frame_start) begin
            top_row  = 1'b1;
            next_col = 0;
            held_ok  = 1'b0;
        end
        // Out-of-range widths clamp to 1 and MAX_WIDTH.
        w = (width_reg == '0) ? 1 : ((int'(width_reg) > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg));
        c = (next_col >= w) ? w - 1 : next_col;
        last = row_end || (c == w - 1);
        up = top_row ? '0 : line_mem[c];
        ul = (c == 0 || top_row) ? '0 : held_up;
        // The held pixel is coded now that its right neighbor has arrived.
        if (held_ok) begin
            code_q.push_back(code_word(direction_code(held_pix, p, up, held_up, held_ul),
                                       1'b0, !last));
        end
        line_mem[c] = p;
        if (last) begin
            code_q.push_back(code_word(direction_code(p, '0, '0, up, ul), 1'b1, 1'b1));
            next_col = 0;
            top_row  = 1'b0;
            held_ok  = 1'b0;
        end else begin
            held_pix = p;
            held_ul  = ul;
            held_up  = up;
            held_ok  = 1'b1;
            next_col = c + 1;
        end
    endtask

    // Compare one accepted code word against the oldest prediction.
    task automatic check_code(input t_result got);
        t_result want;
        if (code_q.size() == 0) begin
            $error("unexpected code word: pattern_code %0d code_row_end %0d last_of_step %0d",
                   got.pattern_code, got.code_row_end, got.last_of_step);
            fail_cnt++;
        end else begin
            want = code_q.pop_front();
            if (got.pattern_code !== want.pattern_code) begin
                $error("pattern_code: expected %0d, actual %0d",
                       want.pattern_code, got.pattern_code);
                fail_cnt++;
            end
            if (got.code_row_end !== want.code_row_end) begin
                $error("code_row_end: expected %0d, actual %0d",
                       want.code_row_end, got.code_row_end);
                fail_cnt++;
            end
            if (got.last_of_step !== want.last_of_step) begin
                $error("last_of_step: expected %0d, actual %0d",
                       want.last_of_step, got.last_of_step);
                fail_cnt++;
            end
        end
    endtask

    // Watch the register port and both channels on every rising edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            held_pix  = '0;
            held_ul   = '0;
            held_up   = '0;
            next_col  = 0;
            held_ok   = 1'b0;
            top_row   = 1'b1;
            width_reg = WIDTH_RESET;
            code_q.delete();
            o_open_codes <= 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr[2] == REG_IMAGE_WIDTH) begin
                width_reg = i_pwdata[CFG_W-1:0];
            end
            if (i_code.valid && i_code.ready) begin
                check_code(code_word(i_code.pattern_code, i_code.code_row_end,
                                     i_code.last_of_step));
            end
            if (i_pix.valid && i_pix.ready) begin
                predict_codes(i_pix.pixel_value, i_pix.row_end, i_pix.frame_start);
            end
            o_open_codes <= code_q.size();
        end
    end

endmodule

FILE: bench/testbench.sv
// Top of the bench: clock, reset, register writes, pixel stimulus and the verdict.
module testbench;
    import gpc_pkg::*;

    localparam logic [APB_ADDR_W-1:0] WIDTH_ADDR = {REG_IMAGE_WIDTH, 2'b00};

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  code_ready = 1'b0;
    logic                  calm = 1'b0;
    int                    stall_left = 0;
    int                    mismatches;
    int                    open_codes;

    gpc_pix_if  pix_ch ();
    gpc_code_if code_ch ();

    assign code_ch.ready = code_ready;

    gradient_pattern_coder dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_pix   (pix_ch),
        .o_code  (code_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    gpc_code_checker checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_pix        (pix_ch),
        .i_code       (code_ch),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_mismatches (mismatches),
        .o_open_codes (open_codes)
    );

    always #5 clk = ~clk;

    // The code receiver stalls in bursts of random length, except in the calm phase.
    always @(posedge clk) begin
        if (calm) begin
            code_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            code_ready <= 1'b0;
        end else if ($urandom_range(0, 4) == 0) begin
            stall_left <= $urandom_range(0, 3);
            code_ready <= 1'b0;
        end else begin
            code_ready <= 1'b1;
        end
    end

    // Safety net against a hung handshake.
    initial begin
        #3000000;
        $display("Mismatches found");
        $finish;
    end

    // Stimulus-side view of the row position, so no row reads a never-written store entry.
    int               row_col = 0;
    bit               in_top_row = 1'b1;
    bit               stored [MAX_WIDTH];
    logic [CFG_W-1:0] cur_width = WIDTH_RESET;
    int               plan_end = 0;
    bit               run_on = 1'b0;

    function automatic int active_width_of(input logic [CFG_W-1:0] w);
        if (w == '0) return 1;
        if (int'(w) > MAX_WIDTH) return MAX_WIDTH;
        return int'(w);
    endfunction

    // Random pixel, often near the extremes so that equal neighbors are common.
    function automatic logic [PIX_W-1:0] pick_pixel();
        case ($urandom_range(0, 3))
            1:       return PIX_W'($urandom_range(0, 3));
            2:       return PIX_W'(255 - $urandom_range(0, 3));
            default: return PIX_W'($urandom);
        endcase
    endfunction

    // Present one pixel word, with an optional gap, and hold it until accepted.
    task automatic send_word(
        input logic [PIX_W-1:0] pv,
        input logic             re,
        input logic             fs
    );
        if (!calm && $urandom_range(0, 4) == 0) begin
            pix_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        pix_ch.valid       <= 1'b1;
        pix_ch.pixel_value <= pv;
        pix_ch.row_end     <= re;
        pix_ch.frame_start <= fs;
        do @(posedge clk); while (!pix_ch.ready);
    endtask

    // Send one pixel, ending the row early where the next column was never stored.
    task automatic drive_pixel(
        input logic [PIX_W-1:0] pv,
        input logic             re,
        input logic             fs
    );
        int w;
        int c;
        bit top;
        w   = active_width_of(cur_width);
        top = in_top_row || fs;
        c   = fs ? 0 : row_col;
        if (c >= w) c = w - 1;
        if (!top && c < w - 1 && !stored[c + 1]) re = 1'b1;
        send_word(pv, re, fs);
        stored[c] = 1'b1;
        if (re || c == w - 1) begin
            row_col    = 0;
            in_top_row = 1'b0;
        end else begin
            row_col    = c + 1;
            in_top_row = top;
        end
    endtask

    // Stop sending and wait until every predicted code word has been taken.
    task automatic settle();
        pix_ch.valid <= 1'b0;
        do @(posedge clk); while (open_codes != 0);
        repeat (6) @(posedge clk);
    endtask

    // Two-phase register write of image_width with random unused upper bits.
    task automatic write_width(input logic [CFG_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= WIDTH_ADDR;
        pwdata  <= {(APB_DATA_W - CFG_W)'($urandom), value};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cur_width = value;
    endtask

    // One random phase at a given width: mostly whole rows, some short and run-on rows.
    task automatic run_phase(input logic [CFG_W-1:0] width_val, input int n, input bit quiet);
        int               w;
        logic             re;
        logic             fs;
        settle();
        write_width(width_val);
        calm <= quiet;
        w = active_width_of(width_val);
        for (int i = 0; i < n; i++) begin
            if (row_col == 0) begin
                case ($urandom_range(0, 19))
                    0, 1, 2:       begin run_on = 1'b1; plan_end = w - 1; end
                    3, 4, 5, 6, 7: begin run_on = 1'b0; plan_end = $urandom_range(0, w - 1); end
                    default:       begin run_on = 1'b0; plan_end = w - 1; end
                endcase
            end
            fs = (row_col == 0 && $urandom_range(0, 5) == 0) || ($urandom_range(0, 49) == 0);
            re = !run_on && (fs ? plan_end == 0 : row_col >= plan_end);
            drive_pixel(pick_pixel(), re, fs);
        end
    endtask

    initial begin
        int guard;
        pix_ch.valid       <= 1'b0;
        pix_ch.pixel_value <= '0;
        pix_ch.row_end     <= 1'b0;
        pix_ch.frame_start <= 1'b0;
        for (int i = 0; i < MAX_WIDTH; i++) stored[i] = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows at width 4.
        write_width(CFG_W'(4));
        // Top row of extremes, ended by row_end.
        drive_pixel(8'd255, 1'b0, 1'b1);
        drive_pixel(8'd0,   1'b0, 1'b0);
        drive_pixel(8'd255, 1'b0, 1'b0);
        drive_pixel(8'd0,   1'b1, 1'b0);
        // Row without row_end that ends on its own at the width.
        drive_pixel(8'd0,   1'b0, 1'b0);
        drive_pixel(8'd255, 1'b0, 1'b0);
        drive_pixel(8'd0,   1'b0, 1'b0);
        drive_pixel(8'd255, 1'b0, 1'b0);
        // Short row with equal pixels.
        drive_pixel(8'd128, 1'b0, 1'b0);
        drive_pixel(8'd128, 1'b1, 1'b0);
        // Full row that reads old store entries beyond the short row.
        drive_pixel(8'd7,   1'b0, 1'b0);
        drive_pixel(8'd200, 1'b0, 1'b0);
        drive_pixel(8'd13,  1'b0, 1'b0);
        drive_pixel(8'd99,  1'b1, 1'b0);
        // Frame start in the middle of a row drops the held pixel.
        drive_pixel(8'd50,  1'b0, 1'b0);
        drive_pixel(8'd60,  1'b0, 1'b0);
        drive_pixel(8'd70,  1'b0, 1'b1);
        drive_pixel(8'd80,  1'b1, 1'b0);
        // Single-pixel rows.
        drive_pixel(8'd255, 1'b1, 1'b0);
        drive_pixel(8'd0,   1'b1, 1'b0);
        // Leave a row open at column 3 so the next, narrower width saturates it.
        drive_pixel(8'd1,   1'b0, 1'b0);
        drive_pixel(8'd2,   1'b0, 1'b0);
        drive_pixel(8'd3,   1'b0, 1'b0);

        // Random phases over a spread of widths, out-of-range ones among them.
        run_phase(CFG_W'(2),   80,  1'b0);
        run_phase(CFG_W'(1),   60,  1'b0);
        run_phase(CFG_W'(0),   60,  1'b0);
        run_phase(CFG_W'(3),   80,  1'b0);
        run_phase(CFG_W'($urandom_range(4, 16)), 100, 1'b0);
        run_phase(CFG_W'(256), 150, 1'b0);
        run_phase(CFG_W'(511), 120, 1'b0);
        run_phase(CFG_W'(300), 100, 1'b0);
        run_phase(CFG_W'($urandom_range(1, 64)), 120, 1'b0);
        run_phase(CFG_W'(8),   100, 1'b1);

        // Drain the remaining code words, then give the verdict.
        pix_ch.valid <= 1'b0;
        guard = 0;
        do begin
            @(posedge clk);
            guard++;
        end while (open_codes != 0 && guard < 5000);
        repeat (8) @(posedge clk);
        if (mismatches == 0 && open_codes == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
